// ===== design/tllc_pkg.sv =====
package tllc_pkg;

  localparam int UE         = 8;
  localparam int LE         = 32;
  localparam int NUM_LEVELS = 2;
  localparam int KEY_BITS   = 16;
  localparam int VALUE_BITS = 32;

  localparam int UIW    = (UE > 1) ? $clog2(UE) : 1;
  localparam int LIW    = (LE > 1) ? $clog2(LE) : 1;
  localparam int UCW    = $clog2(UE + 1);
  localparam int LCW    = $clog2(LE + 1);
  localparam int COST_W = 10;
  localparam int CMP_W  = 10;

  localparam int UCAP_W   = 4;
  localparam int LCAP_W   = 6;
  localparam int COSTR_W  = 8;
  localparam int CFG_IW   = 3;
  localparam int CFG_DW   = 8;

  typedef enum logic [CFG_IW-1:0] {
    CFG_UCAP = 3'd0,
    CFG_LCAP = 3'd1,
    CFG_URC  = 3'd2,
    CFG_UWC  = 3'd3,
    CFG_LRC  = 3'd4,
    CFG_LWC  = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ADD_NONE = 3'd0,
    ADD_URC  = 3'd1,
    ADD_UWC  = 3'd2,
    ADD_LRC  = 3'd3,
    ADD_LWC  = 3'd4
  } add_sel_t;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef struct packed {
    logic     load;
    logic     u_search;
    logic     u_promote;
    logic     u_insert;
    logic     u_fill;
    logic     u_update;
    logic     l_search;
    logic     l_promote;
    logic     l_insert;
    logic     l_update;
    add_sel_t add_sel;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic op;
    logic u_hit;
    logic u_eq;
    logic l_hit;
    logic l_eq;
    logic got_nz;
  } status_t;

endpackage

// ===== design/tllc_req_if.sv =====
interface tllc_req_if;
  import tllc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  opcode;
  logic [KEY_BITS-1:0]   lookup_key;
  logic [VALUE_BITS-1:0] write_data;
  modport source (output valid, opcode, lookup_key, write_data, input ready);
  modport sink (input valid, opcode, lookup_key, write_data, output ready);
endinterface

// ===== design/tllc_rsp_if.sv =====
interface tllc_rsp_if;
  import tllc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  found;
  logic [VALUE_BITS-1:0] read_data;
  logic [COST_W-1:0]     access_cost;
  modport source (output valid, found, read_data, access_cost, input ready);
  modport sink (input valid, found, read_data, access_cost, output ready);
endinterface

// ===== design/two_level_lru_cache_unit.sv =====
// Channel  Direction  Word
// in_ch    in         opcode, lookup_key, write_data
// out_ch   out        found, read_data, access_cost
// cfg_*    in         write enable, register index, write data
//
// Each word is stepped by the controller over the single datapath: a search
// and an action state for each level visited, a fill state for an upper fill
// after a lower read hit, and a done state that loads the result register.
// A new word is taken only from idle, once the last one has been loaded.
// The result register lets the next word be accepted while a result waits;
// a finished word holds in the controller until that register is free.
// Reset is synchronous and empties both levels; no clearing pass is needed.
module two_level_lru_cache_unit
  import tllc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  tllc_req_if.sink          in_ch,
  tllc_rsp_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  cmd_t    cmd;
  status_t status;

  tllc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  tllc_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_opcode (in_ch.opcode),
    .in_key    (in_ch.lookup_key),
    .in_data   (in_ch.write_data),
    .cmd       (cmd),
    .status    (status),
    .out_found (out_ch.found),
    .out_data  (out_ch.read_data),
    .out_cost  (out_ch.access_cost)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted twice in a row");

  a_absent_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.found) |-> (out_ch.read_data == '0))
    else $error("absent result carries data");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(!in_ch.ready))
    else $error("result appeared without a word in progress");

endmodule

// ===== design/tllc_datapath.sv =====
module tllc_datapath
  import tllc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IW-1:0]     cfg_index,
  input  logic [CFG_DW-1:0]     cfg_wdata,
  input  logic                  in_opcode,
  input  logic [KEY_BITS-1:0]   in_key,
  input  logic [VALUE_BITS-1:0] in_data,
  input  cmd_t                  cmd,
  output status_t               status,
  output logic                  out_found,
  output logic [VALUE_BITS-1:0] out_data,
  output logic [COST_W-1:0]     out_cost
);

  logic [UCAP_W-1:0]  ucap_r;
  logic [LCAP_W-1:0]  lcap_r;
  logic [COSTR_W-1:0] urc_r, uwc_r, lrc_r, lwc_r;

  logic                  op_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] data_r, got_r, got_nxt;
  logic [COST_W-1:0]     cost_r, cost_nxt;
  logic [COSTR_W-1:0]    add_c;

  logic [KEY_BITS-1:0]   uk_r [UE], uk_nxt [UE];
  logic [VALUE_BITS-1:0] uv_r [UE], uv_nxt [UE];
  logic [UIW-1:0]        ur_r [UE], ur_nxt [UE];
  logic [UCW-1:0]        ucnt_r, ucnt_nxt;
  logic                  u_hit_c, u_hit_r, u_eq_r, u_full, u_pro;
  logic [UIW-1:0]        u_idx_c, u_idx_r, u_vict, u_pidx, u_last;
  logic [VALUE_BITS-1:0] u_ins_val;

  logic [KEY_BITS-1:0]   lk_r [LE], lk_nxt [LE];
  logic [VALUE_BITS-1:0] lv_r [LE], lv_nxt [LE];
  logic [LIW-1:0]        lr_r [LE], lr_nxt [LE];
  logic [LCW-1:0]        lcnt_r, lcnt_nxt;
  logic                  l_hit_c, l_hit_r, l_eq_r, l_full, l_pro;
  logic [LIW-1:0]        l_idx_c, l_idx_r, l_vict, l_pidx, l_last;

  logic                  out_found_r;
  logic [VALUE_BITS-1:0] out_data_r;
  logic [COST_W-1:0]     out_cost_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ucap_r <= UCAP_W'(8);
      lcap_r <= LCAP_W'(32);
      urc_r  <= COSTR_W'(1);
      uwc_r  <= COSTR_W'(1);
      lrc_r  <= COSTR_W'(1);
      lwc_r  <= COSTR_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_UCAP: ucap_r <= cfg_wdata[UCAP_W-1:0];
        CFG_LCAP: lcap_r <= cfg_wdata[LCAP_W-1:0];
        CFG_URC:  urc_r  <= cfg_wdata;
        CFG_UWC:  uwc_r  <= cfg_wdata;
        CFG_LRC:  lrc_r  <= cfg_wdata;
        CFG_LWC:  lwc_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Associative search: the lowest matching valid entry wins.
  always_comb begin
    u_hit_c = 1'b0;
    u_idx_c = '0;
    for (int i = UE - 1; i >= 0; i--) begin
      if (CMP_W'(i) < CMP_W'(ucnt_r) && uk_r[i] == key_r) begin
        u_hit_c = 1'b1;
        u_idx_c = UIW'(i);
      end
    end
    l_hit_c = 1'b0;
    l_idx_c = '0;
    for (int i = LE - 1; i >= 0; i--) begin
      if (CMP_W'(i) < CMP_W'(lcnt_r) && lk_r[i] == key_r) begin
        l_hit_c = 1'b1;
        l_idx_c = LIW'(i);
      end
    end
  end

  // Victim is the last valid entry holding the oldest rank.
  always_comb begin
    u_last = UIW'(ucnt_r - UCW'(1));
    u_vict = '0;
    for (int i = 0; i < UE; i++) begin
      if (CMP_W'(i) < CMP_W'(ucnt_r) && ur_r[i] == u_last) u_vict = UIW'(i);
    end
    l_last = LIW'(lcnt_r - LCW'(1));
    l_vict = '0;
    for (int i = 0; i < LE; i++) begin
      if (CMP_W'(i) < CMP_W'(lcnt_r) && lr_r[i] == l_last) l_vict = LIW'(i);
    end
    u_full = (CMP_W'(ucnt_r) >= CMP_W'(ucap_r)) || (CMP_W'(ucnt_r) >= CMP_W'(UE));
    l_full = (CMP_W'(lcnt_r) >= CMP_W'(lcap_r)) || (CMP_W'(lcnt_r) >= CMP_W'(LE));
  end

  assign u_ins_val = cmd.u_fill ? got_r : data_r;

  always_comb begin
    uk_nxt   = uk_r;
    uv_nxt   = uv_r;
    ur_nxt   = ur_r;
    ucnt_nxt = ucnt_r;
    u_pro    = cmd.u_promote;
    u_pidx   = u_idx_r;
    if (cmd.u_update) uv_nxt[u_idx_r] = data_r;
    if (cmd.u_insert && ucap_r != '0) begin
      if (u_full) begin
        u_pro          = 1'b1;
        u_pidx         = u_vict;
        uk_nxt[u_vict] = key_r;
        uv_nxt[u_vict] = u_ins_val;
      end else begin
        for (int j = 0; j < UE; j++) begin
          if (CMP_W'(j) < CMP_W'(ucnt_r)) ur_nxt[j] = ur_r[j] + UIW'(1);
        end
        uk_nxt[ucnt_r[UIW-1:0]] = key_r;
        uv_nxt[ucnt_r[UIW-1:0]] = u_ins_val;
        ur_nxt[ucnt_r[UIW-1:0]] = '0;
        ucnt_nxt                = ucnt_r + UCW'(1);
      end
    end
    if (u_pro) begin
      for (int j = 0; j < UE; j++) begin
        if (CMP_W'(j) < CMP_W'(ucnt_r) && ur_r[j] < ur_r[u_pidx]) begin
          ur_nxt[j] = ur_r[j] + UIW'(1);
        end
      end
      ur_nxt[u_pidx] = '0;
    end
  end

  always_comb begin
    lk_nxt   = lk_r;
    lv_nxt   = lv_r;
    lr_nxt   = lr_r;
    lcnt_nxt = lcnt_r;
    l_pro    = cmd.l_promote;
    l_pidx   = l_idx_r;
    if (cmd.l_update) lv_nxt[l_idx_r] = data_r;
    if (cmd.l_insert && lcap_r != '0) begin
      if (l_full) begin
        l_pro          = 1'b1;
        l_pidx         = l_vict;
        lk_nxt[l_vict] = key_r;
        lv_nxt[l_vict] = data_r;
      end else begin
        for (int j = 0; j < LE; j++) begin
          if (CMP_W'(j) < CMP_W'(lcnt_r)) lr_nxt[j] = lr_r[j] + LIW'(1);
        end
        lk_nxt[lcnt_r[LIW-1:0]] = key_r;
        lv_nxt[lcnt_r[LIW-1:0]] = data_r;
        lr_nxt[lcnt_r[LIW-1:0]] = '0;
        lcnt_nxt                = lcnt_r + LCW'(1);
      end
    end
    if (l_pro) begin
      for (int j = 0; j < LE; j++) begin
        if (CMP_W'(j) < CMP_W'(lcnt_r) && lr_r[j] < lr_r[l_pidx]) begin
          lr_nxt[j] = lr_r[j] + LIW'(1);
        end
      end
      lr_nxt[l_pidx] = '0;
    end
  end

  always_comb begin
    case (cmd.add_sel)
      ADD_URC: add_c = urc_r;
      ADD_UWC: add_c = uwc_r;
      ADD_LRC: add_c = lrc_r;
      ADD_LWC: add_c = lwc_r;
      default: add_c = '0;
    endcase
    cost_nxt = cost_r + COST_W'(add_c);
    got_nxt  = got_r;
    if (cmd.u_promote) got_nxt = uv_r[u_idx_r];
    if (cmd.l_promote) got_nxt = lv_r[l_idx_r];
    if (cmd.load) begin
      cost_nxt = '0;
      got_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ucnt_r <= '0;
      lcnt_r <= '0;
    end else begin
      ucnt_r <= ucnt_nxt;
      lcnt_r <= lcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    uk_r   <= uk_nxt;
    uv_r   <= uv_nxt;
    ur_r   <= ur_nxt;
    lk_r   <= lk_nxt;
    lv_r   <= lv_nxt;
    lr_r   <= lr_nxt;
    cost_r <= cost_nxt;
    got_r  <= got_nxt;
    if (cmd.load) begin
      op_r   <= in_opcode;
      key_r  <= in_key;
      data_r <= in_data;
    end
    if (cmd.u_search) begin
      u_hit_r <= u_hit_c;
      u_idx_r <= u_idx_c;
      u_eq_r  <= uv_r[u_idx_c] == data_r;
    end
    if (cmd.l_search) begin
      l_hit_r <= l_hit_c;
      l_idx_r <= l_idx_c;
      l_eq_r  <= lv_r[l_idx_c] == data_r;
    end
    if (cmd.out_load) begin
      out_found_r <= got_r != '0;
      out_data_r  <= got_r;
      out_cost_r  <= cost_r;
    end
  end

  assign status.op     = op_r;
  assign status.u_hit  = u_hit_r;
  assign status.u_eq   = u_eq_r;
  assign status.l_hit  = l_hit_r;
  assign status.l_eq   = l_eq_r;
  assign status.got_nz = got_r != '0;

  assign out_found = out_found_r;
  assign out_data  = out_data_r;
  assign out_cost  = out_cost_r;

endmodule

// ===== design/tllc_ctrl.sv =====
module tllc_ctrl
  import tllc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_U_LOOK = 7'b0000010,
    S_U_ACT  = 7'b0000100,
    S_L_LOOK = 7'b0001000,
    S_L_ACT  = 7'b0010000,
    S_FILL   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  localparam logic HAS_LOWER = NUM_LEVELS > 1;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_U_LOOK;
        end
      end
      S_U_LOOK: begin
        cmd.u_search = 1'b1;
        cmd.add_sel  = ADD_URC;
        state_nxt    = S_U_ACT;
      end
      S_U_ACT: begin
        if (status.op == OP_READ) begin
          if (status.u_hit) begin
            cmd.u_promote = 1'b1;
            state_nxt     = S_DONE;
          end else begin
            state_nxt = HAS_LOWER ? S_L_LOOK : S_DONE;
          end
        end else if (status.u_hit && status.u_eq) begin
          state_nxt = S_DONE;
        end else begin
          cmd.u_update = status.u_hit;
          cmd.u_insert = !status.u_hit;
          cmd.add_sel  = ADD_UWC;
          state_nxt    = HAS_LOWER ? S_L_LOOK : S_DONE;
        end
      end
      S_L_LOOK: begin
        cmd.l_search = 1'b1;
        cmd.add_sel  = ADD_LRC;
        state_nxt    = S_L_ACT;
      end
      S_L_ACT: begin
        if (status.op == OP_READ) begin
          cmd.l_promote = status.l_hit;
          state_nxt     = status.l_hit ? S_FILL : S_DONE;
        end else if (status.l_hit && status.l_eq) begin
          state_nxt = S_DONE;
        end else begin
          cmd.l_update = status.l_hit;
          cmd.l_insert = !status.l_hit;
          cmd.add_sel  = ADD_LWC;
          state_nxt    = S_DONE;
        end
      end
      S_FILL: begin
        if (status.got_nz) begin
          cmd.u_insert = 1'b1;
          cmd.u_fill   = 1'b1;
          cmd.add_sel  = ADD_UWC;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.out_load || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

endmodule
